// ===== sv/heap_permutation_generator_defines.svh =====
// Assertion macros shared by the checker.
`ifndef HEAP_PERMUTATION_GENERATOR_DEFINES_SVH
`define HEAP_PERMUTATION_GENERATOR_DEFINES_SVH

// same-cycle implication
`define HPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hpg_pkg.sv =====
// Types and constants for the permutation generator.
package hpg_pkg;

    localparam int ENTRY_W     = 4;
    localparam int STORE_DEPTH = 16;
    localparam int COUNT_W     = 5;
    localparam int ARR_W       = ENTRY_W * STORE_DEPTH;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ARR_W-1:0]   arr_t;

    localparam count_t COUNT_RESET  = 5'd12;
    localparam arr_t   IDENTITY_ARR = 64'hFEDC_BA98_7654_3210;

endpackage

// ===== sv/heap_permutation_generator.sv =====
// Iterative Heap's-algorithm permutation generator, one step per transfer.
//
// Usage:
//   Input channel (in_valid / in_stall / restart): restart = 1 loads the
//   identity arrangement and emits it; restart = 0 advances one permutation.
//   Output channel (out_valid / out_stall): arrangement, swap_first,
//   swap_second, changed and finished for each input transfer, in order.
//   cfg_wr_en / cfg_wr_data set the number of leading elements permuted;
//   write only while the block is idle. Values above MAX_ELEMENTS act as
//   MAX_ELEMENTS, zero acts as one.
// Timing:
//   The result is in the output register on the edge after the input
//   transfer. One item per cycle is sustained while out_stall is low; the
//   priority find over the loop counters and the swap are combinational.
// Reset: identity order, counters and done flag cleared, count 12,
//   output empty (the output data registers themselves are not reset).
// Stall: while the output register holds a result and out_stall is high,
//   in_stall is raised and the held result stays unchanged.
module heap_permutation_generator #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  hpg_pkg::count_t            cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_stall,
    output hpg_pkg::arr_t              arrangement,
    output hpg_pkg::entry_t            swap_first,
    output hpg_pkg::entry_t            swap_second,
    output logic                       changed,
    output logic                       finished
);

    localparam int EW = hpg_pkg::ENTRY_W;
    localparam int CW = hpg_pkg::COUNT_W;
    localparam int ND = MAX_ELEMENTS;
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam hpg_pkg::count_t MAX_COUNT = CW'(MAX_ELEMENTS);

    hpg_pkg::count_t count_reg;
    hpg_pkg::entry_t order_reg [ND];
    hpg_pkg::entry_t order_next[ND];
    hpg_pkg::entry_t ctr_reg   [ND];
    hpg_pkg::entry_t ctr_next  [ND];
    logic            done_reg, done_next;

    logic            out_valid_reg;
    hpg_pkg::arr_t   arrangement_reg, arrangement_next;
    hpg_pkg::entry_t swap_first_reg, swap_first_next;
    hpg_pkg::entry_t swap_second_reg, swap_second_next;
    logic            changed_reg, changed_next;
    logic            finished_reg;

    logic            accept;
    hpg_pkg::count_t n_eff;
    logic [ND-1:0]   qual, first_hot, below, other_hot;
    logic            found;
    logic [IW-1:0]   sel_idx, other_idx;
    hpg_pkg::entry_t sel_ctr, sel_val, other_val;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (count_reg > MAX_COUNT)
            n_eff = MAX_COUNT;
        else if (count_reg == '0)
            n_eff = CW'(1);
        else
            n_eff = count_reg;

        qual[0] = 1'b0;
        for (int k = 1; k < ND; k++)
            qual[k] = (CW'(k) < n_eff) && (ctr_reg[k] < EW'(k));

        first_hot = qual & (~qual + ND'(1));
        below     = first_hot - ND'(1);
        found     = |qual;

        sel_idx = '0;
        sel_ctr = '0;
        sel_val = '0;
        for (int k = 0; k < ND; k++)
        begin
            if (first_hot[k])
            begin
                sel_idx = sel_idx | IW'(k);
                sel_ctr = sel_ctr | ctr_reg[k];
                sel_val = sel_val | order_reg[k];
            end
        end

        // odd position swaps with the entry its counter points at
        other_idx = sel_idx[0] ? sel_ctr[IW-1:0] : '0;
        other_val = '0;
        for (int k = 0; k < ND; k++)
        begin
            other_hot[k] = (other_idx == IW'(k));
            if (other_hot[k])
                other_val = other_val | order_reg[k];
        end
    end

    always_comb
    begin
        order_next       = order_reg;
        ctr_next         = ctr_reg;
        done_next        = done_reg;
        swap_first_next  = '0;
        swap_second_next = '0;
        changed_next     = 1'b0;

        if (restart)
        begin
            for (int k = 0; k < ND; k++)
            begin
                order_next[k] = EW'(k);
                ctr_next[k]   = '0;
            end
            done_next = 1'b0;
        end
        else if (!done_reg)
        begin
            if (found)
            begin
                for (int k = 0; k < ND; k++)
                begin
                    if (first_hot[k])
                    begin
                        order_next[k] = other_val;
                        ctr_next[k]   = sel_ctr + EW'(1);
                    end
                    else
                    begin
                        if (other_hot[k])
                            order_next[k] = sel_val;
                        if (k >= 1 && below[k])
                            ctr_next[k] = '0;
                    end
                end
                swap_first_next  = EW'(other_idx);
                swap_second_next = EW'(sel_idx);
                changed_next     = 1'b1;
            end
            else
            begin
                for (int k = 1; k < ND; k++)
                    if (CW'(k) < n_eff)
                        ctr_next[k] = '0;
                done_next = 1'b1;
            end
        end

        arrangement_next = hpg_pkg::IDENTITY_ARR;
        for (int k = 0; k < ND; k++)
            arrangement_next[k*EW +: EW] = order_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= hpg_pkg::COUNT_RESET;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < ND; k++)
            begin
                order_reg[k] <= EW'(k);
                ctr_reg[k]   <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            if (accept)
            begin
                order_reg     <= order_next;
                ctr_reg       <= ctr_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arrangement_reg <= arrangement_next;
            swap_first_reg  <= swap_first_next;
            swap_second_reg <= swap_second_next;
            changed_reg     <= changed_next;
            finished_reg    <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign arrangement = arrangement_reg;
    assign swap_first  = swap_first_reg;
    assign swap_second = swap_second_reg;
    assign changed     = changed_reg;
    assign finished    = finished_reg;

endmodule

// ===== sv/hpg_checker.sv =====
// Port-level checks for the permutation generator, bound to heap_permutation_generator.
`include "heap_permutation_generator_defines.svh"

module hpg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cfg_wr_en,
    input hpg_pkg::count_t cfg_wr_data,
    input logic            in_valid,
    input logic            in_stall,
    input logic            restart,
    input logic            out_valid,
    input logic            out_stall,
    input hpg_pkg::arr_t   arrangement,
    input hpg_pkg::entry_t swap_first,
    input hpg_pkg::entry_t swap_second,
    input logic            changed,
    input logic            finished
);

    `HPG_ASSERT_NOW(a_swap_order, out_valid && changed, swap_first < swap_second, "swap positions out of order")

    `HPG_ASSERT_NOW(a_no_swap_zero, out_valid && !changed, swap_first == '0 && swap_second == '0, "swap positions set without a swap")

    `HPG_ASSERT_NOW(a_finished_still, out_valid && finished, !changed, "swap reported after finishing")

    `HPG_ASSERT_NEXT(a_restart_identity, in_valid && !in_stall && restart, out_valid && arrangement == hpg_pkg::IDENTITY_ARR && !finished, "restart did not give identity")

    `HPG_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(arrangement), "stalled result changed")

endmodule

bind heap_permutation_generator hpg_checker u_hpg_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for heap_permutation_generator: predictor, stimulus and checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COUNT = 16;
    localparam int LONG_HOLD = 120;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        hpg_pkg::arr_t   arr;
        hpg_pkg::entry_t lo;
        hpg_pkg::entry_t hi;
        logic            chg;
        logic            fin;
    } perm_step_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    hpg_pkg::count_t cfg_wr_data = '0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic            restart = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    hpg_pkg::arr_t   arrangement;
    hpg_pkg::entry_t swap_first;
    hpg_pkg::entry_t swap_second;
    logic            changed;
    logic            finished;

    hpg_pkg::entry_t order_model [hpg_pkg::STORE_DEPTH];
    hpg_pkg::entry_t counter_model [hpg_pkg::STORE_DEPTH];
    logic            finished_model;
    int              count_model;

    perm_step_t expected_steps[$];
    int mismatch_count = 0;

    int gap_pct = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    heap_permutation_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .arrangement(arrangement),
        .swap_first (swap_first),
        .swap_second(swap_second),
        .changed    (changed),
        .finished   (finished)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #10_000_000;
        $display("[heap_permutation_generator] ERROR");
        $finish;
    end

    function automatic void load_identity_model();
        for (int k = 0; k < hpg_pkg::STORE_DEPTH; k++)
        begin
            order_model[k]   = hpg_pkg::entry_t'(k);
            counter_model[k] = '0;
        end
        finished_model = 1'b0;
    endfunction

    function automatic perm_step_t predict_step(logic rs);
        perm_step_t r;
        int n;
        int idx;
        int other;
        hpg_pkg::entry_t tmp;
        r = '0;
        if (rs)
        begin
            load_identity_model();
        end
        else if (!finished_model)
        begin
            n = count_model;
            if (n > MAX_COUNT)
                n = MAX_COUNT;
            if (n < 1)
                n = 1;
            idx = 0;
            for (int k = 1; k < n; k++)
            begin
                if (idx == 0)
                begin
                    if (int'(counter_model[k]) < k)
                        idx = k;
                    else
                        counter_model[k] = '0;
                end
            end
            if (idx != 0)
            begin
                other = (idx % 2 == 0) ? 0 : int'(counter_model[idx]);
                tmp = order_model[other];
                order_model[other] = order_model[idx];
                order_model[idx] = tmp;
                counter_model[idx] = counter_model[idx] + hpg_pkg::entry_t'(1);
                r.lo  = hpg_pkg::entry_t'(other);
                r.hi  = hpg_pkg::entry_t'(idx);
                r.chg = 1'b1;
            end
            else
            begin
                finished_model = 1'b1;
            end
        end
        for (int k = 0; k < hpg_pkg::STORE_DEPTH; k++)
            r.arr[4*k +: 4] = order_model[k];
        r.fin = finished_model;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // predictor runs on every input transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
            expected_steps.push_back(predict_step(restart));
    end

    always @(posedge clk)
    begin
        perm_step_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_steps.size() == 0)
            begin
                report_mismatch("unexpected result", arrangement, '0);
            end
            else
            begin
                want = expected_steps.pop_front();
                if (arrangement !== want.arr)
                    report_mismatch("arrangement", arrangement, want.arr);
                if (swap_first !== want.lo)
                    report_mismatch("swap_first", 64'(swap_first), 64'(want.lo));
                if (swap_second !== want.hi)
                    report_mismatch("swap_second", 64'(swap_second), 64'(want.hi));
                if (changed !== want.chg)
                    report_mismatch("changed", 64'(changed), 64'(want.chg));
                if (finished !== want.fin)
                    report_mismatch("finished", 64'(finished), 64'(want.fin));
            end
        end
    end

    // receiver stall pattern, plus long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            stall_run = $urandom_range(4);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic idle_input(int cycles);
        in_valid <= 1'b0;
        restart  <= $urandom_range(1);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_step(logic rs);
        if (gap_pct > 0 && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(99) < gap_pct)
                idle_input($urandom_range(1, 6));
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic drain_results();
        idle_input(1);
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_element_count(hpg_pkg::count_t value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_model = int'(value);
    endtask

    task automatic test_restart_and_advance();
        send_step(1'b1);
        repeat (4) send_step(1'b0);
    endtask

    task automatic test_count_extremes();
        set_element_count(5'd1);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        set_element_count(5'd0);
        send_step(1'b0);
        send_step(1'b1);
        set_element_count(5'd2);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        set_element_count(5'd31);
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        // count change without a restart
        set_element_count(5'd16);
        repeat (2) send_step(1'b0);
    endtask

    task automatic test_random_runs();
        int counts[14] = '{3, 4, 2, 5, 6, 17, 16, 12, 1, 4, 3, 31, 0, 7};
        int restart_pct;
        for (int p = 0; p < 14; p++)
        begin
            set_element_count(hpg_pkg::count_t'(counts[p]));
            if (p % 3 == 0)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(20, 50);
                stall_pct = $urandom_range(10, 40);
            end
            restart_pct = (counts[p] >= 2 && counts[p] <= 4) ? 3 : 1;
            if ($urandom_range(99) < 70)
                send_step(1'b1);
            for (int k = 0; k < 135; k++)
                send_step($urandom_range(99) < restart_pct);
        end
    endtask

    task automatic test_backpressure();
        set_element_count(5'd5);
        gap_pct   = 0;
        stall_pct = 0;
        send_step(1'b1);
        hold_asked++;
        repeat (30) send_step(1'b0);
        // sender waits for every result before carrying on
        drain_results();
        gap_pct   = 30;
        stall_pct = 25;
        repeat (20) send_step($urandom_range(99) < 5);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        count_model = int'(hpg_pkg::COUNT_RESET);
        load_identity_model();
        @(posedge clk);
        test_restart_and_advance();
        test_count_extremes();
        test_random_runs();
        test_backpressure();
        drain_results();
        repeat (4) @(posedge clk);
        if (expected_steps.size() != 0)
            report_mismatch("missing results", 64'(expected_steps.size()), '0);
        if (mismatch_count == 0)
            $display("[heap_permutation_generator] OK");
        else
            $display("[heap_permutation_generator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hpg_pkg.sv
sv/heap_permutation_generator.sv
sv/hpg_checker.sv
verif/tb.sv
